/* rtl/stc_pkg.sv */
// Shared types and constants for the symbol table CAM.
// Holds command and status codes and the name normalization function.
// No dependencies.
package stc_pkg;

  localparam int NAME_BYTES = 10;
  localparam int NAME_CHARS = NAME_BYTES - 1;
  localparam int NAME_W     = 72;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef logic [NAME_W-1:0] name_t;

  // Zero every byte after the first zero byte and beyond the character limit.
  function automatic name_t normalize_name(input name_t raw);
    name_t      res;
    logic       ended;
    logic [7:0] b;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < 9; i++) begin
      b = raw[8*i +: 8];
      if (i >= NAME_CHARS || ended) begin
        b = 8'd0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      res[8*i +: 8] = b;
    end
    return res;
  endfunction

endpackage

/* rtl/symbol_table_cam.sv */
// Symbol table CAM top level: input register, parallel label match over all
// slots, table update and result register.
// Depends on stc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: insert,
//   delete or search (code three acts as search) with a label, and for an
//   insert a symbol and an address. Labels and symbols are cut at their
//   first zero byte. The result channel (out_valid/out_ready) returns one
//   beat per command: status, found, entry count after the command and, on
//   a search hit, the stored symbol and address (zero otherwise).
//   A command passes through the input register and then the result register.
//   Throughput: one command per cycle while the receiver takes results; every
//   slot is compared at once in the match stage and the table is written at the
//   edge the command retires, so the next command sees the updated table.
//   Reset clears all slot valid bits and the entry count; the table is empty
//   and usable as soon as reset is released.
//   When the receiver stalls, the result register holds; one more command
//   waits in the input register, then in_ready drops.
module symbol_table_cam
  import stc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_label_low,
  input  logic [7:0]  in_label_high,
  input  logic [63:0] in_symbol_low,
  input  logic [7:0]  in_symbol_high,
  input  logic [15:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [4:0]  out_entry_count,
  output logic [63:0] out_found_symbol_low,
  output logic [7:0]  out_found_symbol_high,
  output logic [15:0] out_found_address
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  name_t       s1_label_r;
  name_t       s1_symbol_r;
  logic [15:0] s1_addr_r;

  // table
  logic [TABLE_ENTRIES-1:0] slot_valid_r, slot_valid_nxt;
  name_t       slot_label_r  [TABLE_ENTRIES];
  name_t       slot_symbol_r [TABLE_ENTRIES];
  logic [15:0] slot_addr_r   [TABLE_ENTRIES];
  logic [CW-1:0] held_count_r, held_count_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_found_r;
  logic [4:0]  out_count_r;
  name_t       out_symbol_r;
  logic [15:0] out_addr_r;

  logic advance;
  logic [TABLE_ENTRIES-1:0] hit_vec, hit_first, free_vec, free_first;
  logic        hit, full, do_insert, do_delete;
  logic [1:0]  status;
  name_t       rd_symbol;
  logic [15:0] rd_addr;
  logic [CW+4:0] count_ext;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r    <= in_command;
      s1_label_r  <= normalize_name({in_label_high, in_label_low});
      s1_symbol_r <= normalize_name({in_symbol_high, in_symbol_low});
      s1_addr_r   <= in_address;
    end
  end

  // match and slot selection
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = slot_valid_r[i] && (slot_label_r[i] == s1_label_r);
    end
    free_vec   = ~slot_valid_r;
    hit_first  = hit_vec & (~hit_vec + 1'b1);
    free_first = free_vec & (~free_vec + 1'b1);
    hit        = |hit_vec;
    full       = ~|free_vec;
  end

  // one-hot readout of the hit slot
  always_comb begin
    rd_symbol = '0;
    rd_addr   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      rd_symbol = rd_symbol | (slot_symbol_r[i] & {NAME_W{hit_first[i]}});
      rd_addr   = rd_addr | (slot_addr_r[i] & {16{hit_first[i]}});
    end
  end

  always_comb begin
    do_insert      = 1'b0;
    do_delete      = 1'b0;
    status         = ST_OK;
    slot_valid_nxt = slot_valid_r;
    held_count_nxt = held_count_r;
    unique case (s1_cmd_r)
      CMD_INSERT: begin
        if (hit) begin
          status = ST_DUP;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_insert      = 1'b1;
          slot_valid_nxt = slot_valid_r | free_first;
          held_count_nxt = held_count_r + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (!hit) begin
          status = ST_MISSING;
        end else begin
          do_delete      = 1'b1;
          slot_valid_nxt = slot_valid_r & ~hit_first;
          held_count_nxt = held_count_r - CW'(1);
        end
      end
      default: begin
        if (!hit) begin
          status = ST_MISSING;
        end
      end
    endcase
  end

  assign count_ext = (CW+5)'(held_count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      held_count_r <= '0;
    end else if (advance && (do_insert || do_delete)) begin
      slot_valid_r <= slot_valid_nxt;
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (advance && do_insert && free_first[i]) begin
        slot_label_r[i]  <= s1_label_r;
        slot_symbol_r[i] <= s1_symbol_r;
        slot_addr_r[i]   <= s1_addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // readout only for a search hit (command three counts as search)
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status;
      out_found_r  <= hit;
      out_count_r  <= count_ext[4:0];
      if (s1_cmd_r != CMD_INSERT && s1_cmd_r != CMD_DELETE) begin
        out_symbol_r <= rd_symbol;
        out_addr_r   <= rd_addr;
      end else begin
        out_symbol_r <= '0;
        out_addr_r   <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_found             = out_found_r;
  assign out_entry_count       = out_count_r;
  assign out_found_symbol_low  = out_symbol_r[63:0];
  assign out_found_symbol_high = out_symbol_r[71:64];
  assign out_found_address     = out_addr_r;

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_count_r) == 32'($countones(slot_valid_r)))
    else $error("entry count differs from number of valid slots");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_count_r) <= 32'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_dup_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_DUP) |-> out_found_r)
    else $error("duplicate status without a hit");

  a_missing_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_MISSING) |-> !out_found_r)
    else $error("not-found status with a hit");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_vec))
    else $error("label held in more than one slot");

endmodule

/* test/symbol_table_cam_test.sv */
// Testbench for the symbol table CAM: random and directed insert, delete and
// search commands, checked against a table model kept in a scoreboard class.
// Depends on stc_pkg and symbol_table_cam.
`timescale 1ns / 1ps

module symbol_table_cam_test
  import stc_pkg::*;
();

  localparam int          TABLE_ENTRIES = 16;
  localparam int          LABEL_POOL    = 24;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          HOLD_CYCLES   = 200;
  localparam logic [1:0]  CMD_SPARE     = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [4:0]  count;
    logic [71:0] symbol;
    logic [15:0] address;
  } lookup_result_t;

  // Table model plus the queue of lookup results still owed by the block.
  class symtab_scoreboard;
    bit             slot_used [TABLE_ENTRIES];
    name_t          slot_label [TABLE_ENTRIES];
    name_t          slot_symbol [TABLE_ENTRIES];
    logic [15:0]    slot_addr [TABLE_ENTRIES];
    int unsigned    held;
    lookup_result_t owed_q[$];
    int             errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      held   = 0;
      errors = 0;
    endfunction

    // C-string cut: keep bytes up to the first zero, at most NAME_CHARS of them.
    function name_t trim_name(name_t raw);
      name_t res;
      res = '0;
      for (int i = 0; i < NAME_CHARS; i++) begin
        if (raw[8*i +: 8] == 8'd0) break;
        res[8*i +: 8] = raw[8*i +: 8];
      end
      return res;
    endfunction

    function void note_command(logic [1:0] cmd, name_t label, name_t symbol,
                               logic [15:0] addr);
      lookup_result_t r;
      name_t          key;
      int             hit_slot;
      int             free_slot;
      key       = trim_name(label);
      hit_slot  = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (hit_slot < 0 && slot_label[i] == key) hit_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      r        = '0;
      r.status = ST_OK;
      r.found  = (hit_slot >= 0);
      case (cmd)
        CMD_INSERT: begin
          if (hit_slot >= 0) begin
            r.status = ST_DUP;
          end else if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[free_slot]   = 1'b1;
            slot_label[free_slot]  = key;
            slot_symbol[free_slot] = trim_name(symbol);
            slot_addr[free_slot]   = addr;
            held++;
          end
        end
        CMD_DELETE: begin
          if (hit_slot < 0) begin
            r.status = ST_MISSING;
          end else begin
            slot_used[hit_slot] = 1'b0;
            held--;
          end
        end
        default: begin
          // search, and the spare code acts the same
          if (hit_slot < 0) begin
            r.status = ST_MISSING;
          end else begin
            r.symbol  = slot_symbol[hit_slot];
            r.address = slot_addr[hit_slot];
          end
        end
      endcase
      r.count = held[4:0];
      owed_q.push_back(r);
    endfunction

    function void flag(string what, logic [71:0] exp_v, logic [71:0] act_v);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result beat expected none actual %0h", $time, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.count !== want.count) flag("entry_count", want.count, got.count);
      if (got.symbol !== want.symbol) flag("found_symbol", want.symbol, got.symbol);
      if (got.address !== want.address) flag("found_address", want.address, got.address);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [63:0] in_label_low;
  logic [7:0]  in_label_high;
  logic [63:0] in_symbol_low;
  logic [7:0]  in_symbol_high;
  logic [15:0] in_address;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_found;
  logic [4:0]  out_entry_count;
  logic [63:0] out_found_symbol_low;
  logic [7:0]  out_found_symbol_high;
  logic [15:0] out_found_address;

  symtab_scoreboard sb;
  bit               in_gaps_on;
  bit               out_stalls_on;
  bit               hold_req;
  int unsigned      cycles;
  name_t            label_pool [LABEL_POOL];
  int               label_len [LABEL_POOL];

  symbol_table_cam #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_label_low          (in_label_low),
    .in_label_high         (in_label_high),
    .in_symbol_low         (in_symbol_low),
    .in_symbol_high        (in_symbol_high),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_found             (out_found),
    .out_entry_count       (out_entry_count),
    .out_found_symbol_low  (out_found_symbol_low),
    .out_found_symbol_high (out_found_symbol_high),
    .out_found_address     (out_found_address)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_command(in_command, {in_label_high, in_label_low},
                      {in_symbol_high, in_symbol_low}, in_address);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_status, out_found, out_entry_count,
                       out_found_symbol_high, out_found_symbol_low, out_found_address});
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !(out_stalls_on && $urandom_range(99) < 21);
    end
  end

  task automatic send_cmd(logic [1:0] cmd, name_t label, name_t symbol, logic [15:0] addr);
    while (in_gaps_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_label_low   <= label[63:0];
    in_label_high  <= label[71:64];
    in_symbol_low  <= symbol[63:0];
    in_symbol_high <= symbol[71:64];
    in_address     <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic name_t rand72();
    return 72'({$urandom, $urandom, $urandom});
  endfunction

  // Pool label, sometimes with junk behind its terminator.
  function automatic name_t dress_label(int idx);
    name_t res;
    res = label_pool[idx];
    if (label_len[idx] < NAME_CHARS && $urandom_range(3) == 0) begin
      for (int i = label_len[idx] + 1; i < 9; i++) res[8*i +: 8] = 8'($urandom_range(255));
    end
    return res;
  endfunction

  function automatic name_t rand_symbol();
    name_t res;
    res = rand72();
    if ($urandom_range(1)) res[8*$urandom_range(8) +: 8] = 8'd0;
    return res;
  endfunction

  task automatic run_random();
    logic [1:0] cmd;
    name_t      label;
    int         mode;
    int         pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 500) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      in_gaps_on    = !(n >= 600 && n < 800);
      out_stalls_on = in_gaps_on;
      // phases: fill toward full, mixed, drain toward empty
      mode = (n / 50) % 3;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 8) begin
        cmd   = 2'($urandom_range(3));
        label = rand72();
      end else begin
        label = dress_label($urandom_range(LABEL_POOL - 1));
        if (pick < (mode == 0 ? 60 : mode == 1 ? 35 : 15)) begin
          cmd = CMD_INSERT;
        end else if (pick < (mode == 0 ? 75 : mode == 1 ? 65 : 70)) begin
          cmd = CMD_DELETE;
        end else begin
          cmd = ($urandom_range(19) == 0) ? CMD_SPARE : CMD_SEARCH;
        end
      end
      send_cmd(cmd, label, rand_symbol(), 16'($urandom_range(16'hffff)));
    end
  endtask

  initial begin
    name_t ones;
    name_t junk_empty;
    name_t short_tail;
    sb            = new();
    cycles        = 0;
    hold_req      = 1'b0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_SEARCH;
    in_label_low   <= '0;
    in_label_high  <= '0;
    in_symbol_low  <= '0;
    in_symbol_high <= '0;
    in_address     <= '0;
    for (int i = 0; i < LABEL_POOL; i++) begin
      label_len[i]  = (i == 0) ? 0 :
                      (i == 1) ? NAME_CHARS : int'($urandom_range(1, NAME_CHARS));
      label_pool[i] = '0;
      for (int j = 0; j < label_len[i]; j++) begin
        label_pool[i][8*j +: 8] = 8'($urandom_range(1, 255));
      end
    end
    ones       = '1;
    junk_empty = {{8{8'hff}}, 8'h00};
    short_tail = {8'h5a, 8'h77, 8'h66, 8'h00, 8'h44, 8'h33, 8'h22, 8'h11, 8'h4b};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and full-width labels, junk after terminators, refusals
    send_cmd(CMD_SEARCH, '0, '0, '0);
    send_cmd(CMD_INSERT, '0, ones, 16'hffff);
    send_cmd(CMD_SEARCH, junk_empty, '0, '0);
    send_cmd(CMD_INSERT, ones, ones, 16'h0000);
    send_cmd(CMD_SEARCH, ones, '0, '0);
    send_cmd(CMD_INSERT, ones, '0, 16'h1234);
    send_cmd(CMD_SPARE, ones, '0, '0);
    send_cmd(CMD_DELETE, 72'h41, '0, '0);
    send_cmd(CMD_DELETE, junk_empty, '0, '0);
    send_cmd(CMD_SEARCH, '0, '0, '0);
    send_cmd(CMD_INSERT, 72'h4b, {8'hee, 8'hdd, 8'hcc, 8'hbb, 8'haa, 8'h00, 8'h43, 8'h42, 8'h41},
             16'h8001);
    send_cmd(CMD_SEARCH, 72'h4b, '0, '0);
    send_cmd(CMD_INSERT, short_tail, 72'h7a7a, 16'h00ff);
    send_cmd(CMD_SEARCH, {32'h0, 40'h44332211_4b}, '0, '0);
    send_cmd(CMD_DELETE, ones, '0, '0);
    send_cmd(CMD_SEARCH, ones, '0, '0);

    run_random();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stc_pkg.sv
rtl/symbol_table_cam.sv
test/symbol_table_cam_test.sv
